/* rtl/core/mppl_pkg.sv */
// shared types and constants of the multichannel pid position loop
// no dependencies
package mppl_pkg;

  localparam int CHANNELS_DEF = 16;
  localparam int SAMPLE_W     = 12;
  localparam int FRAC_W       = 16;
  localparam int FILT_W       = SAMPLE_W + FRAC_W;
  localparam int TGT_W        = 16;
  localparam int ERR_W        = TGT_W + FRAC_W + 2;
  localparam int INTEG_W      = 27;
  localparam int ISUM_W       = ERR_W + 1;
  localparam int ACC_W        = 57;
  localparam int GAIN_W       = 8;
  localparam int LOC_W        = 12;
  localparam int FPROD_W      = GAIN_W + FILT_W;
  localparam int KD_W         = 19;
  localparam int DIV_W        = 40;
  localparam int DSR_W        = 11;
  localparam int RATE_DVD_W   = TGT_W + FRAC_W;
  localparam int RATE_ODD     = 125;
  localparam int RATE_SH      = 4;
  localparam int FOLD_SH      = 8;

  localparam int IN_TDATA_W   = 32;
  localparam int OUT_TDATA_W  = 24;
  localparam int CFG_AW       = 3;
  localparam int CFG_DW       = 12;

  localparam logic [DSR_W-1:0]  RATE_DIV   = DSR_W'(RATE_ODD << RATE_SH);
  localparam logic [GAIN_W-1:0] GAIN_FULL  = GAIN_W'(255);
  localparam logic signed [ISUM_W-1:0] INTEG_LIM = ISUM_W'(500 * (1 << FRAC_W));

  localparam logic [1:0] REQ_SAMPLE = 2'd0;
  localparam logic [1:0] REQ_SET    = 2'd1;
  localparam logic [1:0] REQ_HOLD   = 2'd2;
  localparam logic [1:0] REQ_BAD    = 2'd3;

  localparam logic [CFG_AW-1:0] CFG_PROP   = 3'd0;
  localparam logic [CFG_AW-1:0] CFG_INTEG  = 3'd1;
  localparam logic [CFG_AW-1:0] CFG_DERIV  = 3'd2;
  localparam logic [CFG_AW-1:0] CFG_SMOOTH = 3'd3;
  localparam logic [CFG_AW-1:0] CFG_LIMIT  = 3'd4;
  localparam logic [CFG_AW-1:0] CFG_DEAD   = 3'd5;
  localparam logic [CFG_AW-1:0] CFG_OFFSET = 3'd6;

  typedef enum logic [3:0] {
    ST_IDLE, ST_READ, ST_FMUL1, ST_FMUL2, ST_FDIV, ST_ERR, ST_DZ, ST_IDIV,
    ST_P1, ST_P2, ST_P3, ST_P4, ST_SAT, ST_SDIV, ST_WRITE, ST_OUT
  } state_t;

  typedef struct packed {
    logic [FILT_W-1:0]         filt;
    logic signed [INTEG_W-1:0] integ;
    logic signed [ERR_W-1:0]   lerr;
    logic [TGT_W-1:0]          tgt;
  } chan_state_t;

endpackage

/* rtl/core/multichannel_pid_position_loop_unit.sv */
// Per-channel pid position servo. Channel state (filtered position, integral,
// last error, target) lives in one ram word per channel, read, updated and
// written back by one item at a time. A sample item uses the shared constant
// divider for three divisions (one inside the dead zone), set and hold items
// do not use it; a sample item also waits while the result register is still
// full. Each division by 255 folds the dividend a byte a cycle; the division
// by 2000 is a shift and a reciprocal multiply. After reset all channel state
// reads as zero through per-channel valid bits.
// depends on mppl_pkg, mppl_ram, mppl_cdiv
module multichannel_pid_position_loop_unit #(
  parameter int CHANNELS = mppl_pkg::CHANNELS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [mppl_pkg::IN_TDATA_W-1:0]    in_tdata,   // channel, pot_sample, location
  input  logic [1:0]                         in_tuser,   // req_type
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [mppl_pkg::OUT_TDATA_W-1:0]   out_tdata,  // out_channel, drive, direction, pwm_level
  output logic                               out_tuser,  // in_dead_zone
  input  logic                               cfg_we,
  input  logic [mppl_pkg::CFG_AW-1:0]        cfg_addr,
  input  logic [mppl_pkg::CFG_DW-1:0]        cfg_wdata
);
  import mppl_pkg::*;

  localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  state_t state_r, state_nxt;

  logic [GAIN_W-1:0] prop_r, igain_r, deriv_r, weight_r, limit_r, dead_r;
  logic [LOC_W-1:0]  zoff_r;

  logic [3:0]          in_ch;
  logic [SAMPLE_W-1:0] in_pot;
  logic [LOC_W-1:0]    in_loc;
  logic                in_fire, in_ok;

  logic [1:0]          req_r;
  logic [3:0]          ch_r;
  logic [SAMPLE_W-1:0] raw_r;
  logic [LOC_W-1:0]    loc_r;
  logic                rvld_r;
  logic [CHANNELS-1:0] vld_r;

  logic [FILT_W-1:0]         filt_r;
  logic signed [INTEG_W-1:0] integ_r;
  logic signed [ERR_W-1:0]   lerr_r, err_r;
  logic [TGT_W-1:0]          tgt_r;
  logic [FPROD_W-1:0]        fprod_r, fmul2;
  logic signed [ACC_W-1:0]   acc_r;
  logic signed [54:0]        dm_r, pp_d;
  logic [GAIN_W-1:0]         mag_r;
  logic                      neg_r, dzf_r;

  logic                      out_valid_r, out_dir_r, out_dz_r;
  logic [3:0]                out_ch_r;
  logic [8:0]                out_drive_r, drive9;
  logic [GAIN_W-1:0]         out_pwm_r;
  logic                      out_load;

  logic                      ram_re, ram_we;
  logic [AW-1:0]             ram_raddr, ram_waddr;
  chan_state_t               ram_rdata, ram_wdata, cur;

  logic                      div_start, div_busy, div_done;
  logic [DIV_W-1:0]          div_dvd, div_quot;
  logic                      div_rate;

  logic [ERR_W-1:0]          err_abs, dz_thr;
  logic                      dz_hit;
  logic signed [ERR_W-1:0]   iq_s;
  logic signed [ISUM_W-1:0]  isum, iclamp;
  logic signed [42:0]        pp_prop;
  logic signed [35:0]        pp_int;
  logic signed [ERR_W:0]     diff;
  logic [KD_W-1:0]           kd;
  logic [ACC_W-1:0]          acc_abs;
  logic [15:0]               sat16;
  logic [8:0]                sq;
  logic [GAIN_W-1:0]         mag_nxt;

  assign in_ch   = in_tdata[3:0];
  assign in_pot  = in_tdata[4 +: SAMPLE_W];
  assign in_loc  = in_tdata[16 +: LOC_W];
  assign in_fire = in_tvalid && in_tready;
  assign in_ok   = (in_tuser != REQ_BAD) && (32'(in_ch) < CHANNELS);

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prop_r   <= GAIN_W'(51);
      igain_r  <= GAIN_W'(26);
      deriv_r  <= '0;
      weight_r <= GAIN_W'(51);
      limit_r  <= GAIN_W'(100);
      dead_r   <= GAIN_W'(10);
      zoff_r   <= LOC_W'(1048);
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_PROP:   prop_r   <= cfg_wdata[GAIN_W-1:0];
        CFG_INTEG:  igain_r  <= cfg_wdata[GAIN_W-1:0];
        CFG_DERIV:  deriv_r  <= cfg_wdata[GAIN_W-1:0];
        CFG_SMOOTH: weight_r <= cfg_wdata[GAIN_W-1:0];
        CFG_LIMIT:  limit_r  <= cfg_wdata[GAIN_W-1:0];
        CFG_DEAD:   dead_r   <= cfg_wdata[GAIN_W-1:0];
        CFG_OFFSET: zoff_r   <= cfg_wdata[LOC_W-1:0];
        default: ;
      endcase
    end
  end

  mppl_ram #(.WIDTH($bits(chan_state_t)), .DEPTH(CHANNELS)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  mppl_cdiv #(.DVD_W(DIV_W), .RATE_W(RATE_DVD_W)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .sel_rate (div_rate),
    .dividend (div_dvd),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_quot)
  );

  // datapath terms
  assign cur     = rvld_r ? ram_rdata : '0;
  assign fmul2   = (GAIN_FULL - weight_r) * filt_r;
  assign err_abs = err_r[ERR_W-1] ? ERR_W'(-err_r) : ERR_W'(err_r);
  assign dz_thr  = ERR_W'({dead_r, {FRAC_W{1'b0}}});
  assign dz_hit  = err_abs < dz_thr;
  assign iq_s    = err_r[ERR_W-1] ? -$signed(div_quot[ERR_W-1:0])
                                  : $signed(div_quot[ERR_W-1:0]);
  assign isum    = ISUM_W'(integ_r) + ISUM_W'(iq_s);
  assign iclamp  = (isum > INTEG_LIM) ? INTEG_LIM : ((isum < -INTEG_LIM) ? -INTEG_LIM : isum);
  assign pp_prop = $signed({1'b0, prop_r}) * err_r;
  assign pp_int  = $signed({1'b0, igain_r}) * integ_r;
  assign diff    = (ERR_W + 1)'(err_r) - (ERR_W + 1)'(lerr_r);
  assign kd      = deriv_r * RATE_DIV;
  assign pp_d    = diff * $signed({1'b0, kd});
  assign acc_abs = acc_r[ACC_W-1] ? ACC_W'(-acc_r) : ACC_W'(acc_r);
  assign sat16   = (|acc_abs[ACC_W-1:FRAC_W+16]) ? 16'hFFFF : acc_abs[FRAC_W +: 16];
  assign sq      = div_quot[8:0];
  assign mag_nxt = (sq > {1'b0, limit_r}) ? limit_r : sq[GAIN_W-1:0];
  assign drive9  = neg_r ? -{1'b0, mag_r} : {1'b0, mag_r};

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (in_fire && in_ok) state_nxt = ST_READ;
      ST_READ:  state_nxt = (req_r == REQ_SAMPLE) ? ST_FMUL1 : ST_WRITE;
      ST_FMUL1: state_nxt = ST_FMUL2;
      ST_FMUL2: state_nxt = ST_FDIV;
      ST_FDIV:  if (div_done) state_nxt = ST_ERR;
      ST_ERR:   state_nxt = ST_DZ;
      ST_DZ:    state_nxt = dz_hit ? ST_WRITE : ST_IDIV;
      ST_IDIV:  if (div_done) state_nxt = ST_P1;
      ST_P1:    state_nxt = ST_P2;
      ST_P2:    state_nxt = ST_P3;
      ST_P3:    state_nxt = ST_P4;
      ST_P4:    state_nxt = ST_SAT;
      ST_SAT:   state_nxt = ST_SDIV;
      ST_SDIV:  if (div_done) state_nxt = ST_WRITE;
      ST_WRITE: state_nxt = (req_r == REQ_SAMPLE) ? ST_OUT : ST_IDLE;
      ST_OUT:   if (out_load) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_tready = 1'b0;
    ram_we    = 1'b0;
    div_start = 1'b0;
    div_dvd   = '0;
    div_rate  = 1'b0;
    out_load  = 1'b0;
    case (state_r)
      ST_IDLE:  in_tready = 1'b1;
      ST_FMUL2: begin
        div_start = 1'b1;
        div_dvd   = DIV_W'(fprod_r) + DIV_W'(fmul2);
      end
      ST_DZ: begin
        div_start = !dz_hit;
        div_dvd   = DIV_W'(err_abs);
        div_rate  = 1'b1;
      end
      ST_SAT: begin
        div_start = 1'b1;
        div_dvd   = DIV_W'(sat16);
      end
      ST_WRITE: ram_we = 1'b1;
      ST_OUT:   out_load = !out_valid_r || out_tready;
      default: ;
    endcase
  end

  assign ram_re    = in_fire;
  assign ram_raddr = AW'(in_ch);
  assign ram_waddr = AW'(ch_r);
  assign ram_wdata = '{filt: filt_r, integ: integ_r,
                       lerr: (req_r == REQ_SAMPLE) ? err_r : lerr_r, tgt: tgt_r};

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (ram_we) begin
        vld_r[ram_waddr] <= 1'b1;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // item datapath
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          req_r  <= in_tuser;
          ch_r   <= in_ch;
          raw_r  <= in_pot;
          loc_r  <= in_loc;
          rvld_r <= in_ok && vld_r[AW'(in_ch)];
        end
      end
      ST_READ: begin
        filt_r  <= cur.filt;
        integ_r <= cur.integ;
        lerr_r  <= cur.lerr;
        case (req_r)
          REQ_SET:  tgt_r <= TGT_W'({1'b0, zoff_r} + {1'b0, loc_r});
          REQ_HOLD: tgt_r <= TGT_W'(cur.filt[FILT_W-1:FRAC_W]);
          default:  tgt_r <= cur.tgt;
        endcase
      end
      ST_FMUL1: fprod_r <= weight_r * {raw_r, {FRAC_W{1'b0}}};
      ST_FDIV:  if (div_done) filt_r <= div_quot[FILT_W-1:0];
      ST_ERR:   err_r <= {2'b00, tgt_r, {FRAC_W{1'b0}}} - ERR_W'(filt_r);
      ST_DZ: begin
        dzf_r <= dz_hit;
        if (dz_hit) begin
          integ_r <= '0;
          mag_r   <= '0;
          neg_r   <= 1'b0;
        end
      end
      ST_IDIV:  if (div_done) integ_r <= INTEG_W'(iclamp);
      ST_P1:    acc_r <= ACC_W'(pp_prop);
      ST_P2:    acc_r <= acc_r + ACC_W'(pp_int);
      ST_P3:    dm_r <= pp_d;
      ST_P4:    acc_r <= acc_r + ACC_W'(dm_r);
      ST_SDIV: begin
        if (div_done) begin
          mag_r <= mag_nxt;
          neg_r <= !acc_r[ACC_W-1];
        end
      end
      default: ;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_ch_r    <= ch_r;
      out_drive_r <= drive9;
      out_dir_r   <= !drive9[8];
      out_pwm_r   <= mag_r;
      out_dz_r    <= dzf_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_pwm_r, out_dir_r, out_drive_r, out_ch_r};
  assign out_tuser  = out_dz_r;

`ifndef SYNTHESIS
  a_div_free: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_busy)
    else $error("divider started while busy");

  a_wr_next: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |=> (state_r == ST_IDLE || state_r == ST_OUT))
    else $error("unexpected state after write back");

  a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> (out_valid_r && state_r == ST_IDLE))
    else $error("result item not presented");
`endif

endmodule

/* rtl/core/mppl_ram.sv */
// generic single-port-write ram with registered read
// no dependencies
module mppl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* rtl/core/mppl_cdiv.sv */
// divider by the two loop constants: 255 by folding the dividend a byte per
// cycle, 2000 by a shift and a reciprocal multiply
// depends on mppl_pkg
module mppl_cdiv #(
  parameter int DVD_W  = mppl_pkg::DIV_W,
  parameter int RATE_W = mppl_pkg::RATE_DVD_W
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic             sel_rate,   // 0 divide by 255, 1 divide by 2000
  input  logic [DVD_W-1:0] dividend,
  output logic             busy,
  output logic             done,
  output logic [DVD_W-1:0] quotient
);
  import mppl_pkg::*;

  // 255 = 2^8 - 1, so x = 256a + b folds to 255a + (a + b)
  localparam int FOLDS = (DVD_W + FOLD_SH - 1) / FOLD_SH + 2;
  localparam int CW    = $clog2(FOLDS + 1);
  localparam logic [DVD_W-1:0] FOLD_DEN = DVD_W'((1 << FOLD_SH) - 1);
  // 2000 = 125 << 4; rate dividends stay below 2^RATE_W
  localparam int RW    = RATE_W - RATE_SH;
  localparam int RS    = RW + $clog2(RATE_ODD);
  localparam logic [RW:0] RECIP =
    (RW + 1)'(((64'd1 << RS) + 64'(RATE_ODD) - 64'd1) / 64'(RATE_ODD));

  logic [DVD_W-1:0] x_r, q_r, x_hi;
  logic [CW-1:0]    cnt_r;
  logic             busy_r, done_r, rate_r;
  logic [2*RW:0]    rprod;

  assign x_hi  = x_r >> FOLD_SH;
  assign rprod = x_r[RATE_W-1:RATE_SH] * RECIP;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (rate_r || cnt_r == CW'(FOLDS)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x_r    <= dividend;
      q_r    <= '0;
      rate_r <= sel_rate;
    end else if (busy_r) begin
      if (rate_r) begin
        q_r <= DVD_W'(rprod >> RS);
      end else if (cnt_r == CW'(FOLDS)) begin
        if (x_r == FOLD_DEN) begin
          q_r <= q_r + 1'b1;
        end
      end else begin
        q_r <= q_r + x_hi;
        x_r <= x_hi + DVD_W'(x_r[FOLD_SH-1:0]);
      end
    end
  end

  assign busy     = busy_r;
  assign done     = done_r;
  assign quotient = q_r;

endmodule

/* sim/tb.sv */
// testbench for multichannel_pid_position_loop_unit: directed and random
// requests with a servo-law predictor inside a small scoreboard class
// depends on mppl_pkg and the rtl of the unit
`timescale 1ns / 100ps

module tb;
  import mppl_pkg::*;

  localparam logic [CFG_AW-1:0] CFG_UNUSED = 3'd7;
  localparam int LIMIT_CYCLES = 600000;
  localparam int DRAIN_CYCLES = 80;

  typedef struct packed {
    logic [3:0] chan;
    logic [8:0] drive;
    logic       dir;
    logic [7:0] pwm;
    logic       dz;
  } servo_res_t;

  class servo_board;
    longint unsigned filt [16];
    longint          integ [16];
    longint          lerr [16];
    int unsigned     tgt [16];
    int unsigned     kp, ki, kd, wt, lim, dzone, offs;
    servo_res_t      pending [$];
    int              errors;

    function void clear_state();
      kp = 51; ki = 26; kd = 0; wt = 51; lim = 100; dzone = 10; offs = 1048;
      for (int i = 0; i < 16; i++) begin
        filt[i] = 0; integ[i] = 0; lerr[i] = 0; tgt[i] = 0;
      end
      errors = 0;
    endfunction

    function void write_reg(logic [CFG_AW-1:0] idx, logic [CFG_DW-1:0] val);
      case (idx)
        CFG_PROP:   kp = val[7:0];
        CFG_INTEG:  ki = val[7:0];
        CFG_DERIV:  kd = val[7:0];
        CFG_SMOOTH: wt = val[7:0];
        CFG_LIMIT:  lim = val[7:0];
        CFG_DEAD:   dzone = val[7:0];
        CFG_OFFSET: offs = val;
        default: ;
      endcase
    endfunction

    function void note_item(logic [1:0] req, int ch, int pot, int loc);
      longint e, s, d, drv, one;
      servo_res_t r;
      one = 64'sd65536;
      if (req == REQ_BAD) return;
      if (req == REQ_SET) begin
        tgt[ch] = (offs + loc) & 16'hffff;
        return;
      end
      if (req == REQ_HOLD) begin
        tgt[ch] = (filt[ch] >> 16) & 16'hffff;
        return;
      end
      filt[ch] = (longint'(wt) * (longint'(pot) << 16) + longint'(255 - wt) * filt[ch]) / 255;
      e = longint'(tgt[ch]) * one - longint'(filt[ch]);
      r.chan = 4'(ch);
      if ((e < 0 ? -e : e) < longint'(dzone) * one) begin
        integ[ch] = 0;
        lerr[ch] = e;
        drv = 0;
        r.dz = 1'b1;
      end else begin
        integ[ch] = integ[ch] + e / 2000;
        if (integ[ch] > 500 * one) integ[ch] = 500 * one;
        if (integ[ch] < -500 * one) integ[ch] = -500 * one;
        d = (e - lerr[ch]) * 2000;
        lerr[ch] = e;
        s = longint'(kp) * e + longint'(ki) * integ[ch] + longint'(kd) * d;
        drv = -(s / (255 * one));
        if (drv > longint'(lim)) drv = lim;
        if (drv < -longint'(lim)) drv = -longint'(lim);
        r.dz = 1'b0;
      end
      r.drive = drv[8:0];
      r.dir = (drv >= 0);
      r.pwm = (drv < 0) ? 8'(-drv) : 8'(drv);
      pending.push_back(r);
    endfunction

    function void check_result(logic [OUT_TDATA_W-1:0] data, logic user);
      servo_res_t want, got;
      got = {data[3:0], data[12:4], data[13], data[21:14], user};
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result ch %0d drive %0d", got.chan, got.drive);
        return;
      end
      want = pending.pop_front();
      if (got !== want || data[23:22] !== 2'b00) begin
        errors++;
        if (errors <= 10)
          $display("mismatch exp ch %0d drive %0d dir %0d pwm %0d dz %0d / got ch %0d drive %0d dir %0d pwm %0d dz %0d",
                   want.chan, $signed(want.drive), want.dir, want.pwm, want.dz,
                   got.chan, $signed(got.drive), got.dir, got.pwm, got.dz);
      end
    endfunction
  endclass

  logic clk, rst_n;
  logic in_tvalid, in_tready, out_tvalid, out_tready, out_tuser, cfg_we;
  logic [IN_TDATA_W-1:0] in_tdata;
  logic [1:0] in_tuser;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [CFG_AW-1:0] cfg_addr;
  logic [CFG_DW-1:0] cfg_wdata;
  logic calm;
  int cycles;
  servo_board board;

  multichannel_pid_position_loop_unit i_dut (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) board.check_result(out_tdata, out_tuser);
    out_tready <= calm || ($urandom_range(0, 99) >= 38);
  end

  task automatic send_item(logic [1:0] req, int ch, int pot, int loc);
    while (!calm && $urandom_range(0, 99) < 38) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= req;
    in_tdata <= {4'b0, 12'(loc), 12'(pot), 4'(ch)};
    do @(posedge clk); while (!in_tready);
    board.note_item(req, ch, pot, loc);
  endtask

  task automatic settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (board.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic load_regs(int p, int i, int d, int w, int l, int z, int o);
    int vals [7];
    vals = '{p, i, d, w, l, z, o};
    for (int k = 0; k < 7; k++) begin
      cfg_we <= 1'b1;
      cfg_addr <= CFG_AW'(k);
      cfg_wdata <= (k == 6) ? 12'(o) : {4'($urandom), 8'(vals[k])};
      @(posedge clk);
      board.write_reg(3'(k), (k == 6) ? 12'(o) : 12'(vals[k]));
    end
    cfg_addr <= CFG_UNUSED;
    cfg_wdata <= 12'($urandom);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_phase(int count, int top_ch);
    int roll, ch;
    for (int n = 0; n < count; n++) begin
      roll = $urandom_range(0, 99);
      ch = $urandom_range(0, top_ch);
      calm = (n > count / 2 && n < count / 2 + 30);
      if (roll < 60) send_item(REQ_SAMPLE, ch, $urandom_range(0, 4095), $urandom_range(0, 4095));
      else if (roll < 80) send_item(REQ_SET, ch, $urandom_range(0, 4095), $urandom_range(0, 4095));
      else if (roll < 92) send_item(REQ_HOLD, ch, $urandom_range(0, 4095), $urandom_range(0, 4095));
      else send_item(REQ_BAD, ch, $urandom_range(0, 4095), $urandom_range(0, 4095));
    end
    calm = 1'b0;
    settle();
  endtask

  initial begin
    board = new();
    board.clear_state();
    cycles = 0;
    calm = 1'b0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = REQ_SAMPLE;
    out_tready = 1'b0;
    cfg_we = 1'b0;
    cfg_addr = CFG_PROP;
    cfg_wdata = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_item(REQ_SAMPLE, 0, 0, 0);
    send_item(REQ_SET, 1, 0, 4095);
    for (int k = 0; k < 4; k++) send_item(REQ_SAMPLE, 1, 0, 0);
    send_item(REQ_SET, 2, 4095, 0);
    for (int k = 0; k < 4; k++) send_item(REQ_SAMPLE, 2, 4095, 0);
    send_item(REQ_HOLD, 1, 0, 0);
    send_item(REQ_SAMPLE, 1, 0, 0);
    send_item(REQ_BAD, 3, 4095, 4095);
    send_item(REQ_SAMPLE, 15, 4095, 4095);
    send_item(REQ_HOLD, 15, 0, 0);
    send_item(REQ_SAMPLE, 15, 4095, 0);
    settle();

    random_phase(120, 15);
    load_regs(255, 255, 255, 255, 255, 255, 4095);
    send_item(REQ_SET, 0, 0, 4095);
    send_item(REQ_SAMPLE, 0, 0, 0);
    random_phase(100, 15);
    load_regs(0, 0, 0, 0, 0, 0, 0);
    random_phase(100, 15);
    for (int ph = 0; ph < 4; ph++) begin
      load_regs($urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 40),
                $urandom_range(1, 255), $urandom_range(0, 255), $urandom_range(0, 30),
                $urandom_range(0, 4095));
      random_phase(100, (ph % 2) ? 1 : 15);
    end

    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/core/mppl_pkg.sv
rtl/core/mppl_ram.sv
rtl/core/mppl_cdiv.sv
rtl/core/multichannel_pid_position_loop_unit.sv
sim/tb.sv
